// File: hdl/cau_pkg.sv
package cau_pkg;

    // Quotient bits a divide produces: 32 result bits plus one guard bit that
    // makes any saturating quotient visible.
    localparam int QBITS = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               overflow;
        logic               div_by_zero;
    } cau_out_t;

    // One quotient lane of the divider: partial remainder and the shift
    // register that feeds numerator bits in and collects quotient bits.
    typedef struct packed {
        logic             neg;
        logic             big;
        logic [63:0]      rem;
        logic [QBITS-1:0] ql;
    } cau_lane_t;

    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic [63:0] den;
        logic [31:0] fix_re;
        logic [31:0] fix_im;
        logic        fix_ovf;
        cau_lane_t   lane_re;
        cau_lane_t   lane_im;
    } cau_item_t;

    // Saturate a sign and magnitude to 32-bit two's complement; bit 32 is overflow.
    function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else                               r = {1'b0, mag[31:0]};
        end else begin
            if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
            else                               r = {1'b0, ~mag[31:0] + 32'd1};
        end
        return r;
    endfunction

    // Saturate a 33-bit two's complement sum to 32 bits; bit 32 is overflow.
    function automatic logic [32:0] sat_sum(input logic [32:0] s);
        logic [32:0] r;
        if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        else                r = {1'b0, s[31:0]};
        return r;
    endfunction

endpackage

// File: hdl/cau_front.sv
module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          adv,
    input  logic                v_in,
    input  cau_pkg::cau_in_t    data_in,
    output logic [2:0]          v_out,
    output cau_pkg::cau_item_t  item_out
);

    localparam int NW = 64 + cau_pkg::QBITS;

    // Products stage, which also holds the add and subtract sums.
    logic [2:0]          v_reg;
    logic [1:0]          op1_reg;
    logic signed [32:0]  s1_re_reg, s1_im_reg;
    logic signed [63:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;

    // Sums stage.
    logic [1:0]          op2_reg;
    logic [32:0]         as_re_reg, as_im_reg;
    logic signed [64:0]  x_re_reg, x_im_reg;
    logic [63:0]         den_reg;

    cau_pkg::cau_item_t  item_next, item_reg;

    logic signed [32:0]  ar, ai, br, bi;
    logic [64:0]         mag_re, mag_im;
    logic [32:0]         mul_re, mul_im;
    logic [NW-1:0]       num_re, num_im;
    logic                big_re, big_im;

    assign ar = 33'(data_in.a_re);
    assign ai = 33'(data_in.a_im);
    assign br = 33'(data_in.b_re);
    assign bi = 33'(data_in.b_im);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= v_in;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            op1_reg   <= data_in.opcode;
            s1_re_reg <= (data_in.opcode == cau_pkg::OP_SUB) ? ar - br : ar + br;
            s1_im_reg <= (data_in.opcode == cau_pkg::OP_SUB) ? ai - bi : ai + bi;
            p_rr_reg  <= data_in.a_re * data_in.b_re;
            p_ii_reg  <= data_in.a_im * data_in.b_im;
            p_ri_reg  <= data_in.a_re * data_in.b_im;
            p_ir_reg  <= data_in.a_im * data_in.b_re;
            p_bb_reg  <= data_in.b_re * data_in.b_re;
            p_cc_reg  <= data_in.b_im * data_in.b_im;
        end
        if (adv[1]) begin
            op2_reg   <= op1_reg;
            as_re_reg <= cau_pkg::sat_sum(s1_re_reg);
            as_im_reg <= cau_pkg::sat_sum(s1_im_reg);
            if (op1_reg == cau_pkg::OP_MUL) begin
                x_re_reg <= 65'(p_rr_reg) - 65'(p_ii_reg);
                x_im_reg <= 65'(p_ri_reg) + 65'(p_ir_reg);
            end else begin
                x_re_reg <= 65'(p_rr_reg) + 65'(p_ii_reg);
                x_im_reg <= 65'(p_ir_reg) - 65'(p_ri_reg);
            end
            den_reg   <= p_bb_reg[63:0] + p_cc_reg[63:0];
        end
        if (adv[2]) item_reg <= item_next;
    end

    // Magnitudes, the multiply result and the divider's starting remainder.
    always_comb begin
        mag_re = x_re_reg[64] ? 65'd0 - x_re_reg : x_re_reg;
        mag_im = x_im_reg[64] ? 65'd0 - x_im_reg : x_im_reg;
        mul_re = cau_pkg::sat_mag(x_re_reg[64], mag_re[63:0] >> FRAC_BITS);
        mul_im = cau_pkg::sat_mag(x_im_reg[64], mag_im[63:0] >> FRAC_BITS);
        num_re = {{cau_pkg::QBITS{1'b0}}, mag_re[63:0]} << FRAC_BITS;
        num_im = {{cau_pkg::QBITS{1'b0}}, mag_im[63:0]} << FRAC_BITS;
        big_re = num_re[NW-1:cau_pkg::QBITS] >= den_reg;
        big_im = num_im[NW-1:cau_pkg::QBITS] >= den_reg;

        item_next.is_div = (op2_reg == cau_pkg::OP_DIV);
        item_next.dz     = (op2_reg == cau_pkg::OP_DIV) && (den_reg == 64'd0);
        item_next.den    = den_reg;
        if (op2_reg == cau_pkg::OP_MUL) begin
            item_next.fix_re  = mul_re[31:0];
            item_next.fix_im  = mul_im[31:0];
            item_next.fix_ovf = mul_re[32] | mul_im[32];
        end else begin
            item_next.fix_re  = as_re_reg[31:0];
            item_next.fix_im  = as_im_reg[31:0];
            item_next.fix_ovf = as_re_reg[32] | as_im_reg[32];
        end
        item_next.lane_re.neg = x_re_reg[64];
        item_next.lane_re.big = big_re;
        item_next.lane_re.rem = big_re ? 64'd0 : num_re[NW-1:cau_pkg::QBITS];
        item_next.lane_re.ql  = num_re[cau_pkg::QBITS-1:0];
        item_next.lane_im.neg = x_im_reg[64];
        item_next.lane_im.big = big_im;
        item_next.lane_im.rem = big_im ? 64'd0 : num_im[NW-1:cau_pkg::QBITS];
        item_next.lane_im.ql  = num_im[cau_pkg::QBITS-1:0];
    end

    assign v_out    = v_reg;
    assign item_out = item_reg;

endmodule

// File: hdl/cau_div_cell.sv
module cau_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                v_in,
    input  cau_pkg::cau_item_t  item_in,
    output logic                v_out,
    output cau_pkg::cau_item_t  item_out
);

    logic               v_reg;
    cau_pkg::cau_item_t item_reg, item_next;

    // One restoring step: bring in the next numerator bit, subtract if it fits.
    function automatic cau_pkg::cau_lane_t step(input cau_pkg::cau_lane_t l,
                                                input logic [63:0] den);
        cau_pkg::cau_lane_t r;
        logic [64:0]        rs;
        logic               fit;
        rs    = {l.rem, l.ql[cau_pkg::QBITS-1]};
        fit   = rs >= {1'b0, den};
        r     = l;
        r.rem = fit ? 64'(rs - {1'b0, den}) : rs[63:0];
        r.ql  = {l.ql[cau_pkg::QBITS-2:0], fit};
        return r;
    endfunction

    always_comb begin
        item_next         = item_in;
        item_next.lane_re = step(item_in.lane_re, item_in.den);
        item_next.lane_im = step(item_in.lane_im, item_in.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) item_reg <= item_next;
    end

    assign v_out    = v_reg;
    assign item_out = item_reg;

endmodule

// File: hdl/complex_arithmetic_unit.sv
// Path: the edge that accepts a word on s_ loads the first of three operand
// stages; two more operand stages, 33 divider cells and one output register
// follow before its result is presented on m_.
// Throughput: one word per cycle for every opcode while m_ready holds; the 33-cell divider chain
// sets the depth, not the rate.
// Reset: aresetn, synchronous and active low, empties every stage; data
// registers keep their contents but are never presented as valid.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cau_pkg::cau_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cau_pkg::cau_out_t   m_data
);

    // Stage numbering: 0..2 front end, 3..35 divider cells, 36 output register.
    localparam int NCELL  = cau_pkg::QBITS;
    localparam int NSTAGE = NCELL + 4;

    logic [NSTAGE-1:0]  vld;
    logic [NSTAGE-1:0]  adv;
    cau_pkg::cau_item_t chain [0:NCELL];

    logic               m_valid_reg;
    cau_pkg::cau_out_t  m_data_reg, m_data_next;
    logic [32:0]        pk_re, pk_im;
    logic [63:0]        q_re, q_im;

    // Each stage moves when it is empty or its successor moves, so bubbles
    // collapse and a waiting result stalls only the stages behind it.
    assign adv[NSTAGE-1] = !m_valid_reg || m_ready;
    assign vld[NSTAGE-1] = m_valid_reg;

    genvar k;
    generate
        for (k = 0; k < NSTAGE - 1; k++) begin : g_adv
            assign adv[k] = !vld[k] || adv[k+1];
        end
    endgenerate

    assign s_ready = adv[0];

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv[2:0]),
        .v_in     (s_valid),
        .data_in  (s_data),
        .v_out    (vld[2:0]),
        .item_out (chain[0])
    );

    // One cell per quotient bit, most significant first.
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            cau_div_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .adv      (adv[k+3]),
                .v_in     (vld[k+2]),
                .item_in  (chain[k]),
                .v_out    (vld[k+3]),
                .item_out (chain[k+1])
            );
        end
    endgenerate

    // Final saturation. A quotient that overran the guard bit is forced to a
    // value that always saturates.
    always_comb begin
        q_re  = chain[NCELL].lane_re.big ? 64'h0000_0001_0000_0000
                                         : 64'(chain[NCELL].lane_re.ql);
        q_im  = chain[NCELL].lane_im.big ? 64'h0000_0001_0000_0000
                                         : 64'(chain[NCELL].lane_im.ql);
        pk_re = cau_pkg::sat_mag(chain[NCELL].lane_re.neg, q_re);
        pk_im = cau_pkg::sat_mag(chain[NCELL].lane_im.neg, q_im);

        if (!chain[NCELL].is_div) begin
            m_data_next.res_re      = chain[NCELL].fix_re;
            m_data_next.res_im      = chain[NCELL].fix_im;
            m_data_next.overflow    = chain[NCELL].fix_ovf;
            m_data_next.div_by_zero = 1'b0;
        end else if (chain[NCELL].dz) begin
            m_data_next.res_re      = '0;
            m_data_next.res_im      = '0;
            m_data_next.overflow    = 1'b0;
            m_data_next.div_by_zero = 1'b1;
        end else begin
            m_data_next.res_re      = pk_re[31:0];
            m_data_next.res_im      = pk_im[31:0];
            m_data_next.overflow    = pk_re[32] | pk_im[32];
            m_data_next.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv[NSTAGE-1]) begin
            m_valid_reg <= vld[NSTAGE-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTAGE-1]) m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A divide by zero always returns a clean zero result.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.div_by_zero |->
            m_data.res_re == 32'sd0 && m_data.res_im == 32'sd0 && !m_data.overflow)
        else $error("divide by zero result not cleared");

    // An overflow means at least one part sits at a saturation limit.
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            m_data.res_re == 32'h7FFF_FFFF || m_data.res_re == 32'h8000_0000 ||
            m_data.res_im == 32'h7FFF_FFFF || m_data.res_im == 32'h8000_0000)
        else $error("overflow flagged without a saturated part");

    // With no result held, the whole pipeline drains and the input is open.
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
